// File: hdl/phm_pkg.sv
`default_nettype none

package phm_pkg;

  // Default geometry and counter width of the pixel grid.
  localparam int ROWS_DEFAULT        = 576;
  localparam int COLS_DEFAULT        = 1152;
  localparam int COUNT_WIDTH_DEFAULT = 24;

  // Field widths fixed by the interface.
  localparam int COORD_WIDTH = 20;
  localparam int HALF_WIDTH  = 19;
  localparam int PLANE_WIDTH = 3;
  localparam int LIMIT_WIDTH = 24;
  localparam int INDEX_WIDTH = 20;
  localparam int CNT_OUT_WIDTH = 24;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 24;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SELECTED_PLANE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_X_HALF_RANGE   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_Y_HALF_RANGE   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOT_LIMIT      = 2'd3;

  // Register values after reset.
  localparam logic [PLANE_WIDTH-1:0] SELECTED_PLANE_RESET = 3'd0;
  localparam logic [HALF_WIDTH-1:0]  X_HALF_RANGE_RESET   = 19'd176000;
  localparam logic [HALF_WIDTH-1:0]  Y_HALF_RANGE_RESET   = 19'd88000;
  localparam logic [LIMIT_WIDTH-1:0] HOT_LIMIT_RESET      = 24'd16777215;

  // Operation codes.
  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_FILTER     = 1'b1;

endpackage

`default_nettype wire

// File: hdl/phm_ram.sv
`default_nettype none

// Single-port synchronous RAM with a registered read.
module phm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire                                  clk,
  input  wire                                  we,
  input  wire                                  re,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire  [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read share the one address port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/pixel_hit_map_hot_pixel_mask.sv
// Pixel hit map with hot pixel mask.
// Input channel (in_valid / in_stall): one detector hit per transfer, with
// operation, hit_x, hit_y and hit_plane. Output channel (out_valid /
// out_stall): one result per hit, with pixel_index, in_range, plane_match,
// pixel_count, is_hot and keep_hit. Configuration is written through
// cfg_en / cfg_index / cfg_data; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// Each hit is handled on its own: offset and range check, scaling multiply,
// a restoring divider for column and row that yields one quotient bit per
// cycle, pixel address, a counter read and a write back. An out-of-range
// hit goes from the range check straight to the write back.
// The result sits in an output register, so a stalled receiver holds only
// the write-back step; the next hit is taken while the result waits.
// After reset the counter memory is cleared one entry per cycle, and
// in_stall stays high until the clearing pass is done.
`default_nettype none

module pixel_hit_map_hot_pixel_mask #(
  parameter int ROWS        = phm_pkg::ROWS_DEFAULT,
  parameter int COLS        = phm_pkg::COLS_DEFAULT,
  parameter int COUNT_WIDTH = phm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire                                     clk,
  input  wire                                     rst,
  // Configuration port.
  input  wire                                     cfg_en,
  input  wire  [phm_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  wire  [phm_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
  // Input channel.
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     operation,
  input  wire  signed [phm_pkg::COORD_WIDTH-1:0]  hit_x,
  input  wire  signed [phm_pkg::COORD_WIDTH-1:0]  hit_y,
  input  wire  [phm_pkg::PLANE_WIDTH-1:0]         hit_plane,
  // Output channel.
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic [phm_pkg::INDEX_WIDTH-1:0]         pixel_index,
  output logic                                    in_range,
  output logic                                    plane_match,
  output logic [phm_pkg::CNT_OUT_WIDTH-1:0]       pixel_count,
  output logic                                    is_hot,
  output logic                                    keep_hit
);

  localparam int MAXN = (ROWS > COLS) ? ROWS : COLS;
  localparam int MW   = $clog2(MAXN + 1);
  localparam int QW   = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int OW   = phm_pkg::HALF_WIDTH + 1;
  localparam int NW   = OW + MW;
  localparam int PW   = QW + MW + 1;
  localparam int NPIX = ROWS * COLS;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int SW   = (QW > 1) ? $clog2(QW) : 1;
  localparam int CW   = COUNT_WIDTH;
  localparam int HW   = phm_pkg::HALF_WIDTH;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_OFF  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PIX  = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // Configuration registers.
  logic [phm_pkg::PLANE_WIDTH-1:0] selected_plane;
  logic [HW-1:0]                   x_half_range;
  logic [HW-1:0]                   y_half_range;
  logic [phm_pkg::LIMIT_WIDTH-1:0] hot_limit;

  // Sequencer and item registers.
  logic [2:0]                            state;
  logic [AW-1:0]                         clr_addr;
  logic [SW-1:0]                         step;
  logic                                  op;
  logic                                  match;
  logic                                  inr;
  logic signed [phm_pkg::COORD_WIDTH-1:0] hx;
  logic signed [phm_pkg::COORD_WIDTH-1:0] hy;
  logic [OW-1:0]                         offx;
  logic [OW-1:0]                         offy;
  logic [OW-1:0]                         remx;
  logic [OW-1:0]                         remy;
  logic [QW-1:0]                         lowx;
  logic [QW-1:0]                         lowy;
  logic [QW-1:0]                         qx;
  logic [QW-1:0]                         qy;
  logic [PW-1:0]                         pix;

  // Combinational helpers.
  logic signed [OW:0] offx_s;
  logic signed [OW:0] offy_s;
  logic [OW-1:0]      span_x;
  logic [OW-1:0]      span_y;
  logic               inx;
  logic               iny;
  logic [NW-1:0]      prod_x;
  logic [NW-1:0]      prod_y;
  logic [OW:0]        trial_x;
  logic [OW:0]        trial_y;
  logic               qbit_x;
  logic               qbit_y;
  logic [PW-1:0]      pix_full;
  logic [CW-1:0]      cnt_old;
  logic [CW-1:0]      cnt_new;
  logic               inc;
  logic               hot;
  logic               out_free;
  logic               wb_go;

  // Memory port.
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [CW-1:0] ram_wdata;
  logic [CW-1:0] rdata;

  // Configuration writes; unknown indices cannot occur with a two-bit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      selected_plane <= phm_pkg::SELECTED_PLANE_RESET;
      x_half_range   <= phm_pkg::X_HALF_RANGE_RESET;
      y_half_range   <= phm_pkg::Y_HALF_RANGE_RESET;
      hot_limit      <= phm_pkg::HOT_LIMIT_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index)
        phm_pkg::REG_SELECTED_PLANE: selected_plane <= cfg_data[phm_pkg::PLANE_WIDTH-1:0];
        phm_pkg::REG_X_HALF_RANGE:   x_half_range   <= cfg_data[HW-1:0];
        phm_pkg::REG_Y_HALF_RANGE:   y_half_range   <= cfg_data[HW-1:0];
        phm_pkg::REG_HOT_LIMIT:      hot_limit      <= cfg_data[phm_pkg::LIMIT_WIDTH-1:0];
      endcase
    end
  end

  // Offset into the area and range check for both axes.
  always_comb begin
    offx_s = (OW + 1)'(hx) + $signed({2'b00, x_half_range});
    offy_s = (OW + 1)'(hy) + $signed({2'b00, y_half_range});
    span_x = {x_half_range, 1'b0};
    span_y = {y_half_range, 1'b0};
    inx    = (x_half_range != '0) && !offx_s[OW] && (offx_s[OW-1:0] < span_x);
    iny    = (y_half_range != '0) && !offy_s[OW] && (offy_s[OW-1:0] < span_y);
  end

  // Scaling by the grid size before the division.
  assign prod_x = NW'(offx) * NW'(COLS);
  assign prod_y = NW'(offy) * NW'(ROWS);

  // One restoring division step per axis.
  always_comb begin
    trial_x = {remx, lowx[QW-1]};
    trial_y = {remy, lowy[QW-1]};
    qbit_x  = (trial_x >= {1'b0, span_x});
    qbit_y  = (trial_y >= {1'b0, span_y});
  end

  // Pixel address, clamped to the last pixel.
  always_comb begin
    pix_full = PW'(qy) * PW'(COLS) + PW'(qx);
    if (pix_full >= PW'(NPIX)) begin
      pix_full = PW'(NPIX - 1);
    end
  end

  // Counter update and hot decision at write back.
  always_comb begin
    cnt_old = inr ? rdata : '0;
    inc     = inr && (op == phm_pkg::OP_ACCUMULATE) && match && (cnt_old != CNT_MAX);
    cnt_new = inc ? cnt_old + CW'(1) : cnt_old;
    hot     = inr && (32'(cnt_new) > 32'(hot_limit));
  end

  assign out_free = !out_valid || !out_stall;
  assign wb_go    = (state == S_WB) && out_free;
  assign in_stall = (state != S_IDLE);

  // Memory port selection: clearing pass, read, or write back.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = pix[AW-1:0];
    ram_wdata = cnt_new;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr;
      ram_wdata = '0;
    end else if (state == S_RD) begin
      ram_re = 1'b1;
    end else if (wb_go && inc) begin
      ram_we = 1'b1;
    end
  end

  phm_ram #(
    .WIDTH (CW),
    .DEPTH (NPIX)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      step     <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (clr_addr == AW'(NPIX - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_OFF;
          end
        end
        S_OFF: begin
          state <= (inx && iny) ? S_MUL : S_WB;
        end
        S_MUL: begin
          state <= S_DIV;
          step  <= '0;
        end
        S_DIV: begin
          if (step == SW'(QW - 1)) begin
            state <= S_PIX;
          end
          step <= step + SW'(1);
        end
        S_PIX: begin
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WB;
        end
        S_WB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Item datapath.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      op    <= operation;
      hx    <= hit_x;
      hy    <= hit_y;
      match <= (hit_plane == selected_plane);
    end
    if (state == S_OFF) begin
      inr  <= inx && iny;
      offx <= offx_s[OW-1:0];
      offy <= offy_s[OW-1:0];
    end
    if (state == S_MUL) begin
      remx <= prod_x[QW +: OW];
      remy <= prod_y[QW +: OW];
      lowx <= prod_x[QW-1:0];
      lowy <= prod_y[QW-1:0];
      qx   <= '0;
      qy   <= '0;
    end
    if (state == S_DIV) begin
      remx <= qbit_x ? OW'(trial_x - {1'b0, span_x}) : trial_x[OW-1:0];
      remy <= qbit_y ? OW'(trial_y - {1'b0, span_y}) : trial_y[OW-1:0];
      lowx <= lowx << 1;
      lowy <= lowy << 1;
      qx   <= QW'({qx, qbit_x});
      qy   <= QW'({qy, qbit_y});
    end
    if (state == S_PIX) begin
      pix <= pix_full;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      pixel_index <= inr ? phm_pkg::INDEX_WIDTH'(pix) : '0;
      in_range    <= inr;
      plane_match <= match;
      pixel_count <= phm_pkg::CNT_OUT_WIDTH'(cnt_new);
      is_hot      <= hot;
      keep_hit    <= inr && (op == phm_pkg::OP_FILTER) && match && !hot;
    end
  end

  // No result may appear while the memory is being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !out_valid)
    else $error("result valid during clearing pass");

  // A new result only comes from the write-back step.
  a_out_from_wb: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_WB))
    else $error("result raised outside write back");

  // A counter write outside clearing is always the read value plus one.
  a_write_inc: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state != S_CLR)) |-> (ram_wdata == rdata + CW'(1)))
    else $error("counter write is not an increment");

  // An accepted hit starts the offset step next.
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_OFF))
    else $error("accepted hit did not start processing");

  // The divider never runs past its last quotient bit.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (step <= SW'(QW - 1)))
    else $error("divider step out of bounds");

endmodule

`default_nettype wire
